// ===== rtl/stq_pkg.sv =====
// shared types and constants of the sorted timer queue
// no dependencies
package stq_pkg;

   localparam int TIMERS = 16;
   localparam int ID_W = $clog2(TIMERS);
   localparam int LEN_W = $clog2(TIMERS + 1);
   localparam int SEC_W = 32;
   localparam int NSEC_W = 30;
   localparam int ENTRY_W = 2 * SEC_W + 2 * NSEC_W;

   localparam logic [NSEC_W:0] NS_PER_SEC = 31'd1000000000;

   localparam logic [1:0] CMD_START = 2'd0;
   localparam logic [1:0] CMD_STOP = 2'd1;
   localparam logic [1:0] CMD_TICK = 2'd2;

   // operation on the expiry order list
   typedef struct packed {
      logic wr_en;
      logic [ID_W-1:0] wr_idx;
      logic [ID_W-1:0] wr_data;
      logic del_en;
      logic [ID_W-1:0] del_idx;
   } order_cmd_type;

endpackage

// ===== rtl/stq_ram.sv =====
// generic single write, single read ram with registered read data
// no dependencies
module stq_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== rtl/stq_order.sv =====
// expiry order list: timer ids from earliest to latest expiry
// depends on stq_pkg
module stq_order (
   input  logic                            clock,
   input  stq_pkg::order_cmd_type          cmd,
   input  logic [stq_pkg::ID_W-1:0]        rd_idx,
   output logic [stq_pkg::ID_W-1:0]        rd_data
);

   localparam int ID_W = stq_pkg::ID_W;

   logic [stq_pkg::ID_W-1:0] q_ff [stq_pkg::TIMERS];
   logic [stq_pkg::ID_W-1:0] q_in [stq_pkg::TIMERS];

   always_comb begin
      for (int k = 0; k < stq_pkg::TIMERS; k++) begin
         q_in[k] = q_ff[k];
         // delete closes the gap by pulling the upper neighbor down
         if (cmd.del_en && (k < stq_pkg::TIMERS - 1) &&
             (ID_W'(k) >= cmd.del_idx)) begin
            q_in[k] = q_ff[(k + 1) % stq_pkg::TIMERS];
         end
         if (cmd.wr_en && (cmd.wr_idx == ID_W'(k))) begin
            q_in[k] = cmd.wr_data;
         end
      end
   end

   always_ff @(posedge clock) begin
      for (int k = 0; k < stq_pkg::TIMERS; k++) begin
         q_ff[k] <= q_in[k];
      end
   end

   assign rd_data = q_ff[rd_idx];

endmodule

// ===== rtl/sorted_timer_queue.sv =====
// sorted timer queue top level: command sequencer, timer ram and order list
// depends on stq_pkg, stq_ram, stq_order
//
// the req channel takes one command word: start arms a timer with an expiry
// time and reload period, stop disarms it, tick gives the current time.
// the rsp channel returns one word per expired timer of a tick, in expiry
// order, with last set on the final one. start, stop and an empty tick
// return nothing.
// timer expiry and period live in a ram with registered read data.
// a start or stop scans the order list once to remove the timer, and a
// start then inserts it, moving each entry that expires later up one
// place. a tick scans the list, checks each timer not yet fired, and
// re-inserts a due periodic timer after adding its period to its expiry.
// req_stall is high while a command is in progress.
// results pass through an output register and one held word, so a stall
// on rsp only holds the sequencer when both are full.
// reset disarms all timers and empties the list; the ram is not cleared.
module sorted_timer_queue (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_stall,
   input  logic [1:0]                    req_cmd,
   input  logic [stq_pkg::ID_W-1:0]      req_timer_id,
   input  logic [stq_pkg::SEC_W-1:0]     req_time_sec,
   input  logic [stq_pkg::NSEC_W-1:0]    req_time_nsec,
   input  logic [stq_pkg::SEC_W-1:0]     req_period_sec_in,
   input  logic [stq_pkg::NSEC_W-1:0]    req_period_nsec_in,
   output logic                          rsp_valid,
   input  logic                          rsp_stall,
   output logic [stq_pkg::ID_W-1:0]      rsp_expired_id,
   output logic                          rsp_last
);

   localparam int ID_W = stq_pkg::ID_W;
   localparam int LEN_W = stq_pkg::LEN_W;
   localparam int SEC_W = stq_pkg::SEC_W;
   localparam int NSEC_W = stq_pkg::NSEC_W;
   localparam int N = stq_pkg::TIMERS;

   localparam logic [3:0] S_IDLE = 4'd0;
   localparam logic [3:0] S_REM = 4'd1;
   localparam logic [3:0] S_INS_RD = 4'd2;
   localparam logic [3:0] S_INS_CMP = 4'd3;
   localparam logic [3:0] S_SCAN = 4'd4;
   localparam logic [3:0] S_CHK = 4'd5;
   localparam logic [3:0] S_DUE = 4'd6;
   localparam logic [3:0] S_RSUM = 4'd7;
   localparam logic [3:0] S_RNORM = 4'd8;
   localparam logic [3:0] S_END = 4'd9;

   logic [3:0] state_ff, state_in;
   logic [1:0] cmd_ff, cmd_in;
   logic [ID_W-1:0] cand_ff, cand_in;
   logic [SEC_W-1:0] tsec_ff, tsec_in;
   logic [NSEC_W-1:0] tnsec_ff, tnsec_in;
   logic [SEC_W-1:0] psec_ff, psec_in;
   logic [NSEC_W-1:0] pnsec_ff, pnsec_in;
   logic [SEC_W-1:0] esec_ff, esec_in;
   logic [NSEC_W-1:0] ensec_ff, ensec_in;
   logic [SEC_W-1:0] new_sec_ff, new_sec_in;
   logic [NSEC_W-1:0] new_nsec_ff, new_nsec_in;
   logic [NSEC_W:0] sum_ns_ff, sum_ns_in;
   logic [LEN_W-1:0] len_ff, len_in;
   logic [LEN_W-1:0] idx_ff, idx_in;
   logic [ID_W-1:0] pos_ff, pos_in;
   logic found_ff, found_in;
   logic ret_tick_ff, ret_tick_in;
   logic [N-1:0] fired_ff, fired_in;
   logic held_valid_ff, held_valid_in;
   logic [ID_W-1:0] held_id_ff, held_id_in;
   logic rsp_valid_ff, rsp_valid_in;
   logic [ID_W-1:0] rsp_id_ff, rsp_id_in;
   logic rsp_last_ff, rsp_last_in;

   stq_pkg::order_cmd_type ord_cmd;
   logic [ID_W-1:0] ord_rd_idx;
   logic [ID_W-1:0] ord_rd_data;

   logic ram_wr_en;
   logic [ID_W-1:0] ram_wr_addr;
   logic [stq_pkg::ENTRY_W-1:0] ram_wr_data;
   logic [ID_W-1:0] ram_rd_addr;
   logic [stq_pkg::ENTRY_W-1:0] ram_rd_data;

   logic [SEC_W-1:0] rd_esec;
   logic [NSEC_W-1:0] rd_ensec;
   logic [SEC_W-1:0] rd_psec;
   logic [NSEC_W-1:0] rd_pnsec;
   logic out_free;
   logic due;
   logic ins_later;

   // ram word: expiry sec, expiry nsec, period sec, period nsec
   assign rd_esec = ram_rd_data[2*NSEC_W+2*SEC_W-1 -: SEC_W];
   assign rd_ensec = ram_rd_data[2*NSEC_W+SEC_W-1 -: NSEC_W];
   assign rd_psec = ram_rd_data[NSEC_W+SEC_W-1 -: SEC_W];
   assign rd_pnsec = ram_rd_data[NSEC_W-1:0];

   assign out_free = !rsp_valid_ff || !rsp_stall;
   assign due = !((esec_ff > tsec_ff) || ((esec_ff == tsec_ff) && (ensec_ff > tnsec_ff)));
   assign ins_later = (rd_esec > new_sec_ff) ||
                      ((rd_esec == new_sec_ff) && (rd_ensec > new_nsec_ff));

   stq_ram #(
      .WIDTH(stq_pkg::ENTRY_W),
      .DEPTH(N)
   ) u_ram (
      .clock(clock),
      .wr_en(ram_wr_en),
      .wr_addr(ram_wr_addr),
      .wr_data(ram_wr_data),
      .rd_addr(ram_rd_addr),
      .rd_data(ram_rd_data)
   );

   stq_order u_order (
      .clock(clock),
      .cmd(ord_cmd),
      .rd_idx(ord_rd_idx),
      .rd_data(ord_rd_data)
   );

   always_comb begin
      state_in = state_ff;
      cmd_in = cmd_ff;
      cand_in = cand_ff;
      tsec_in = tsec_ff;
      tnsec_in = tnsec_ff;
      psec_in = psec_ff;
      pnsec_in = pnsec_ff;
      esec_in = esec_ff;
      ensec_in = ensec_ff;
      new_sec_in = new_sec_ff;
      new_nsec_in = new_nsec_ff;
      sum_ns_in = sum_ns_ff;
      len_in = len_ff;
      idx_in = idx_ff;
      pos_in = pos_ff;
      found_in = found_ff;
      ret_tick_in = ret_tick_ff;
      fired_in = fired_ff;
      held_valid_in = held_valid_ff;
      held_id_in = held_id_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      rsp_id_in = rsp_id_ff;
      rsp_last_in = rsp_last_ff;

      ord_cmd = '0;
      ord_rd_idx = idx_ff[ID_W-1:0];
      ram_wr_en = 1'b0;
      ram_wr_addr = cand_ff;
      ram_wr_data = {new_sec_ff, new_nsec_ff, psec_ff, pnsec_ff};
      ram_rd_addr = ord_rd_data;

      case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               cmd_in = req_cmd;
               cand_in = req_timer_id;
               new_sec_in = req_time_sec;
               new_nsec_in = req_time_nsec;
               tsec_in = req_time_sec;
               tnsec_in = req_time_nsec;
               psec_in = req_period_sec_in;
               pnsec_in = req_period_nsec_in;
               idx_in = '0;
               found_in = 1'b0;
               if (req_cmd == stq_pkg::CMD_START || req_cmd == stq_pkg::CMD_STOP) begin
                  state_in = S_REM;
               end else if (req_cmd == stq_pkg::CMD_TICK) begin
                  fired_in = '0;
                  held_valid_in = 1'b0;
                  state_in = S_SCAN;
               end
            end
         end
         S_REM: begin
            if (idx_ff == len_ff) begin
               len_in = len_ff - LEN_W'(found_ff);
               if (cmd_ff == stq_pkg::CMD_START) begin
                  ram_wr_en = 1'b1;
                  pos_in = ID_W'(len_ff - LEN_W'(found_ff));
                  ret_tick_in = 1'b0;
                  state_in = S_INS_RD;
               end else begin
                  state_in = S_IDLE;
               end
            end else begin
               if (!found_ff && ord_rd_data == cand_ff) begin
                  found_in = 1'b1;
               end else if (found_ff) begin
                  ord_cmd.wr_en = 1'b1;
                  ord_cmd.wr_idx = idx_ff[ID_W-1:0] - ID_W'(1);
                  ord_cmd.wr_data = ord_rd_data;
               end
               idx_in = idx_ff + LEN_W'(1);
            end
         end
         S_INS_RD: begin
            ord_rd_idx = pos_ff - ID_W'(1);
            if (pos_ff == '0) begin
               ord_cmd.wr_en = 1'b1;
               ord_cmd.wr_idx = '0;
               ord_cmd.wr_data = cand_ff;
               len_in = len_ff + LEN_W'(1);
               state_in = ret_tick_ff ? S_SCAN : S_IDLE;
            end else begin
               state_in = S_INS_CMP;
            end
         end
         S_INS_CMP: begin
            ord_rd_idx = pos_ff - ID_W'(1);
            ord_cmd.wr_en = 1'b1;
            ord_cmd.wr_idx = pos_ff;
            if (ins_later) begin
               // entry below expires later, move it up one place
               ord_cmd.wr_data = ord_rd_data;
               pos_in = pos_ff - ID_W'(1);
               state_in = S_INS_RD;
            end else begin
               ord_cmd.wr_data = cand_ff;
               len_in = len_ff + LEN_W'(1);
               state_in = ret_tick_ff ? S_SCAN : S_IDLE;
            end
         end
         S_SCAN: begin
            if (idx_ff == len_ff) begin
               state_in = S_END;
            end else if (fired_ff[ord_rd_data]) begin
               idx_in = idx_ff + LEN_W'(1);
            end else begin
               cand_in = ord_rd_data;
               state_in = S_CHK;
            end
         end
         S_CHK: begin
            esec_in = rd_esec;
            ensec_in = rd_ensec;
            psec_in = rd_psec;
            pnsec_in = rd_pnsec;
            state_in = S_DUE;
         end
         S_DUE: begin
            if (!due) begin
               state_in = S_END;
            end else if (!held_valid_ff || out_free) begin
               if (held_valid_ff) begin
                  rsp_valid_in = 1'b1;
                  rsp_id_in = held_id_ff;
                  rsp_last_in = 1'b0;
               end
               held_valid_in = 1'b1;
               held_id_in = cand_ff;
               fired_in[cand_ff] = 1'b1;
               ord_cmd.del_en = 1'b1;
               ord_cmd.del_idx = idx_ff[ID_W-1:0];
               len_in = len_ff - LEN_W'(1);
               // entries below idx are all fired, the scan resumes there
               if (psec_ff != '0 || pnsec_ff != '0) begin
                  state_in = S_RSUM;
               end else begin
                  state_in = S_SCAN;
               end
            end
         end
         S_RSUM: begin
            sum_ns_in = {1'b0, ensec_ff} + {1'b0, pnsec_ff};
            new_sec_in = esec_ff + psec_ff;
            state_in = S_RNORM;
         end
         S_RNORM: begin
            if (sum_ns_ff >= stq_pkg::NS_PER_SEC) begin
               sum_ns_in = sum_ns_ff - stq_pkg::NS_PER_SEC;
               new_sec_in = new_sec_ff + SEC_W'(1);
            end else begin
               new_nsec_in = sum_ns_ff[NSEC_W-1:0];
               ram_wr_en = 1'b1;
               ram_wr_data = {new_sec_ff, sum_ns_ff[NSEC_W-1:0], psec_ff, pnsec_ff};
               pos_in = len_ff[ID_W-1:0];
               ret_tick_in = 1'b1;
               state_in = S_INS_RD;
            end
         end
         S_END: begin
            if (!held_valid_ff) begin
               state_in = S_IDLE;
            end else if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_id_in = held_id_ff;
               rsp_last_in = 1'b1;
               held_valid_in = 1'b0;
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         len_ff <= '0;
         fired_ff <= '0;
         held_valid_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         len_ff <= len_in;
         fired_ff <= fired_in;
         held_valid_ff <= held_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      cmd_ff <= cmd_in;
      cand_ff <= cand_in;
      tsec_ff <= tsec_in;
      tnsec_ff <= tnsec_in;
      psec_ff <= psec_in;
      pnsec_ff <= pnsec_in;
      esec_ff <= esec_in;
      ensec_ff <= ensec_in;
      new_sec_ff <= new_sec_in;
      new_nsec_ff <= new_nsec_in;
      sum_ns_ff <= sum_ns_in;
      idx_ff <= idx_in;
      pos_ff <= pos_in;
      found_ff <= found_in;
      ret_tick_ff <= ret_tick_in;
      held_id_ff <= held_id_in;
      rsp_id_ff <= rsp_id_in;
      rsp_last_ff <= rsp_last_in;
   end

   assign req_stall = (state_ff != S_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_expired_id = rsp_id_ff;
   assign rsp_last = rsp_last_ff;

endmodule
